[hw/rtl/smp_pkg.sv]
package smp_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic [CNT_W-1:0]         t_count;
    typedef logic [ADDR_W-1:0]        t_addr;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

endpackage

[hw/rtl/smp_ifs.sv]
interface smp_in_if;
    logic                   valid;
    logic                   ready;
    smp_pkg::t_sample       sample;
    logic                   final_in;

    modport source (output valid, output sample, output final_in, input ready);
    modport sink   (input valid, input sample, input final_in, output ready);
endinterface

interface smp_out_if;
    logic                   valid;
    logic                   ready;
    smp_pkg::t_sample       sample_out;
    logic                   final_out;
    logic                   overflow;

    modport source (output valid, output sample_out, output final_out, output overflow,
                    input ready);
    modport sink   (input valid, input sample_out, input final_out, input overflow,
                    output ready);
endinterface

interface smp_cfg_if;
    logic                   valid;
    logic                   ready;
    smp_pkg::t_sample       threshold;

    modport source (output valid, output threshold, input ready);
    modport sink   (input valid, input threshold, output ready);
endinterface

[hw/rtl/smp_ram.sv]
module smp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/stable_magnitude_partition_core.sv]
// Stable partition of a run of signed Q16.16 samples by magnitude. A sample above the
// threshold or below its negative leaves through the output register in the cycle after
// its acceptance; other samples go into a 64-entry hold RAM. When the sample flagged
// final_in is accepted, the held samples are drained in arrival order and the last result
// of the run carries final_out, plus overflow if any small sample was dropped for lack of
// room. A sample is accepted only while no drain runs and the output register can take a
// result; each drained sample is first read from the RAM, then loaded into the output
// register once it is free. The threshold channel is always ready and should only be
// written between runs.
module stable_magnitude_partition_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    smp_cfg_if.sink       i_cfg,
    smp_in_if.sink        i_in,
    smp_out_if.source     o_out
);
    import smp_pkg::*;

    t_state  r_state, n_state;
    t_sample r_threshold;
    t_count  r_cnt, n_cnt;
    logic    r_drop, n_drop;
    t_count  r_len, n_len;
    t_count  r_idx, n_idx;
    logic    r_run_ovf, n_run_ovf;

    logic    r_out_valid, n_out_valid;
    t_sample r_out_sample, n_out_sample;
    logic    r_out_final, n_out_final;
    logic    r_out_ovf, n_out_ovf;

    logic    out_free;
    logic    in_take;
    logic    big;
    logic    full;
    logic    last_rd;
    logic    ram_we;
    logic    ram_re;
    t_sample ram_rdata;

    logic signed [DATA_W:0] samp_ext;
    logic signed [DATA_W:0] thr_ext;
    logic signed [DATA_W:0] thr_neg;

    assign i_cfg.ready = 1'b1;

    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign in_take = i_in.valid && i_in.ready;

    assign samp_ext = {i_in.sample[DATA_W-1], i_in.sample};
    assign thr_ext  = {r_threshold[DATA_W-1], r_threshold};
    assign thr_neg  = -thr_ext;
    assign big      = (samp_ext > thr_ext) || (samp_ext < thr_neg);
    assign full     = (r_cnt == t_count'(CAPACITY));
    assign last_rd  = (r_idx == (r_len - t_count'(1)));

    assign ram_we = in_take && !big && !full;
    assign ram_re = (r_state == S_READ);

    smp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY),
        .AW    (ADDR_W)
    ) u_hold (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (i_in.sample),
        .i_re    (ram_re),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take && i_in.final_in && (n_len != '0)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_state = last_rd ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        t_count adj_cnt;
        logic   adj_drop;

        adj_cnt      = r_cnt;
        adj_drop     = r_drop;
        n_cnt        = r_cnt;
        n_drop       = r_drop;
        n_len        = r_len;
        n_idx        = r_idx;
        n_run_ovf    = r_run_ovf;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_sample = r_out_sample;
        n_out_final  = r_out_final;
        n_out_ovf    = r_out_ovf;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (big) begin
                        // large final sample with a full buffer loses the newest held one
                        if (i_in.final_in && full) begin
                            adj_cnt  = t_count'(CAPACITY - 1);
                            adj_drop = 1'b1;
                        end
                        n_out_valid  = 1'b1;
                        n_out_sample = i_in.sample;
                        n_out_final  = i_in.final_in && (adj_cnt == '0);
                        n_out_ovf    = i_in.final_in && (adj_cnt == '0) && adj_drop;
                    end else if (full) begin
                        adj_drop = 1'b1;
                    end else begin
                        adj_cnt = r_cnt + t_count'(1);
                    end
                    n_cnt  = adj_cnt;
                    n_drop = adj_drop;
                    if (i_in.final_in) begin
                        n_len     = adj_cnt;
                        n_idx     = '0;
                        n_run_ovf = adj_drop;
                        n_cnt     = '0;
                        n_drop    = 1'b0;
                    end
                end
            end
            S_READ: begin
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = ram_rdata;
                    n_out_final  = last_rd;
                    n_out_ovf    = last_rd && r_run_ovf;
                    n_idx        = r_idx + t_count'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_threshold <= '0;
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_threshold <= i_cfg.threshold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len        <= n_len;
        r_idx        <= n_idx;
        r_run_ovf    <= n_run_ovf;
        r_out_sample <= n_out_sample;
        r_out_final  <= n_out_final;
        r_out_ovf    <= n_out_ovf;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.final_out  = r_out_final;
    assign o_out.overflow   = r_out_ovf;

endmodule

[dv/stable_magnitude_partition_core_tb.sv]
`timescale 1ns / 1ps

module stable_magnitude_partition_core_tb;

    import smp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_OFF     = 400;
    localparam int DRAIN_WAIT   = 8;

    typedef struct packed {
        t_sample sample;
        logic    fin;
    } t_item;

    typedef struct packed {
        t_sample sample_out;
        logic    final_out;
        logic    overflow;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    smp_cfg_if cfg_if ();
    smp_in_if  in_if ();
    smp_out_if out_if ();

    stable_magnitude_partition_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #6 i_clk = ~i_clk;

    // partition predictor state
    t_sample held_q[$];
    logic    drop_seen = 1'b0;
    t_sample thr_q     = '0;

    t_item   pend_q[$];
    t_result exp_q[$];

    int  items_queued = 0;
    int  items_taken  = 0;
    int  mismatches   = 0;
    int  cycle_cnt    = 0;
    bit  in_took      = 1'b0;
    bit  stall_go     = 1'b0;
    bit  stall_spent  = 1'b0;
    int  stall_left   = 0;
    wire calm         = (items_taken >= 70) && (items_taken < 150);

    function automatic void add_result(t_sample value, bit last);
        t_result r;
        r.sample_out = value;
        r.final_out  = last;
        r.overflow   = last ? drop_seen : 1'b0;
        exp_q.push_back(r);
    endfunction

    function automatic void partition_step(t_sample s, logic fin);
        longint v;
        longint t;
        bit     big;
        int     n;
        v   = longint'(s);
        t   = longint'(thr_q);
        big = (v > t) || (v < -t);
        if (big) begin
            if (fin && held_q.size() >= CAPACITY) begin
                void'(held_q.pop_back());
                drop_seen = 1'b1;
            end
            add_result(s, fin && held_q.size() == 0);
        end else if (held_q.size() < CAPACITY) begin
            held_q.push_back(s);
        end else begin
            drop_seen = 1'b1;
        end
        if (fin) begin
            n = held_q.size();
            for (int i = 0; i < n; i++) begin
                add_result(held_q[i], i == n - 1);
            end
            held_q.delete();
            drop_seen = 1'b0;
        end
    endfunction

    function automatic t_sample draw_small(int mag);
        return t_sample'(longint'($urandom_range(0, 2 * mag)) - mag);
    endfunction

    function automatic t_sample draw_sample();
        longint t;
        longint base;
        int     sel;
        t   = longint'(thr_q);
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            base = $urandom_range(0, 1) ? t : -t;
            return t_sample'(base + longint'($urandom_range(0, 2)) - 1);
        end else if (sel < 6 && t > 0 && t < (64'sd1 << 30)) begin
            return draw_small(int'(t));
        end
        return t_sample'($urandom);
    endfunction

    task automatic add_item(t_sample s, logic fin);
        t_item it;
        it.sample = s;
        it.fin    = fin;
        pend_q.push_back(it);
        items_queued++;
    endtask

    task automatic add_random_runs(int total);
        int left;
        int len;
        left = total;
        while (left > 0) begin
            len = $urandom_range(1, 8);
            if (len > left) len = left;
            for (int i = 0; i < len; i++) add_item(draw_sample(), i == len - 1);
            left -= len;
        end
    endtask

    task automatic add_small_run(int count, int mag);
        for (int i = 0; i < count; i++) add_item(draw_small(mag), i == count - 1);
    endtask

    task automatic settle();
        do @(negedge i_clk); while (items_taken != items_queued || exp_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_threshold(t_sample value);
        @(negedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.threshold <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        thr_q = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // driver
    always @(negedge i_clk) begin
        t_item nxt;
        if (!in_if.valid || in_took) begin
            if (pend_q.size() > 0 && (calm || $urandom_range(0, 99) >= 6)) begin
                nxt = pend_q.pop_front();
                in_if.valid    <= 1'b1;
                in_if.sample   <= nxt.sample;
                in_if.final_in <= nxt.fin;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    always @(negedge i_clk) begin
        if (stall_go && !stall_spent) begin
            stall_spent = 1'b1;
            stall_left  = HOLD_OFF;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm || ($urandom_range(0, 99) >= 6);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        in_took = i_rst_n && in_if.valid && in_if.ready;
        if (in_took) begin
            partition_step(in_if.sample, in_if.final_in);
            items_taken++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (exp_q.size() == 0) begin
                $error("unexpected transaction: sample_out 0x%08h", out_if.sample_out);
                mismatches++;
            end else begin
                want = exp_q.pop_front();
                if (out_if.sample_out !== want.sample_out) begin
                    $error("sample_out: expected 0x%08h, got 0x%08h",
                           want.sample_out, out_if.sample_out);
                    mismatches++;
                end
                if (out_if.final_out !== want.final_out) begin
                    $error("final_out: expected %0b, got %0b",
                           want.final_out, out_if.final_out);
                    mismatches++;
                end
                if (out_if.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b",
                           want.overflow, out_if.overflow);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("stable_magnitude_partition_core_tb: errors");
            $finish;
        end
    end

    initial begin
        in_if.valid      = 1'b0;
        in_if.sample     = '0;
        in_if.final_in   = 1'b0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.threshold = '0;
        i_rst_n          = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero threshold after reset
        add_item(32'sh0000_0000, 1'b0);
        add_item(32'sh0000_0001, 1'b0);
        add_item(32'shFFFF_FFFF, 1'b0);
        add_item(32'sh7FFF_FFFF, 1'b0);
        add_item(32'sh8000_0000, 1'b0);
        add_item(32'sh0000_0000, 1'b1);
        add_item(32'sh0000_0005, 1'b1);
        add_item(32'sh0000_0000, 1'b1);
        settle();

        write_threshold(32'sh0001_0000);
        add_item(32'sh0001_0000, 1'b0);
        add_item(32'shFFFF_0000, 1'b0);
        add_item(32'sh0001_0001, 1'b0);
        add_item(32'shFFFE_FFFF, 1'b0);
        add_item(32'sh0000_8000, 1'b0);
        add_item(32'sh7FFF_FFFF, 1'b1);
        add_random_runs(2);
        settle();

        // output held off while input keeps coming
        @(posedge i_clk);
        stall_go = 1'b1;
        add_random_runs(10);
        settle();

        write_threshold(32'sh7FFF_FFFF);
        add_item(32'sh7FFF_FFFF, 1'b0);
        add_item(32'sh8000_0000, 1'b0);
        add_item(32'sh8000_0001, 1'b1);
        add_random_runs(2);
        settle();

        // negative thresholds pass everything through
        write_threshold(32'sh8000_0000);
        add_item(32'sh0000_0000, 1'b0);
        add_item(32'sh7FFF_FFFF, 1'b0);
        add_item(32'sh8000_0000, 1'b1);
        add_random_runs(2);
        settle();

        write_threshold(32'shFFFF_FFFF);
        add_random_runs(3);
        settle();

        // hold buffer overfilled, then a large last element with the buffer full
        write_threshold(32'sh0000_0100);
        for (int i = 0; i <= CAPACITY; i++) add_item(draw_small(256), 1'b0);
        add_item(32'sh0001_0000, 1'b1);
        add_small_run(3, 256);
        settle();

        for (int k = 0; k < 3; k++) begin
            write_threshold(k == 1 ? t_sample'($urandom) : t_sample'($urandom_range(0, 1 << 20)));
            add_random_runs(2);
            settle();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("stable_magnitude_partition_core_tb: clean");
        end else begin
            $display("stable_magnitude_partition_core_tb: errors");
        end
        $finish;
    end

endmodule
